// ===== sv/u8u16_pkg.sv =====
package u8u16_pkg;

    localparam logic [15:0] REPL_UNIT  = 16'hFFFD;
    localparam logic [15:0] HI_SURR    = 16'hD800;
    localparam logic [15:0] LO_SURR    = 16'hDC00;
    localparam logic [20:0] SURR_MIN   = 21'h00D800;
    localparam logic [20:0] SURR_MAX   = 21'h00DFFF;
    localparam logic [20:0] POINT_MAX  = 21'h10FFFF;
    localparam logic [20:0] BMP_MAX    = 21'h00FFFF;
    localparam logic [20:0] PLANE_BASE = 21'h010000;
    localparam logic [20:0] MIN_LEN2   = 21'h000080;
    localparam logic [20:0] MIN_LEN3   = 21'h000800;
    localparam logic [20:0] MIN_LEN4   = 21'h010000;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // units of one input byte: n_repl replacement units, then n_tail tail units
    typedef struct packed {
        logic [2:0]  n_repl;
        logic [1:0]  n_tail;
        logic [15:0] tail0;
        logic [15:0] tail1;
    } t_burst;

endpackage

// ===== sv/u8u16_decode.sv =====
module u8u16_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    input  logic                i_end,
    output logic                o_push,
    output u8u16_pkg::t_burst   o_burst
);

    logic [2:0]  r_len;
    logic [1:0]  r_held;
    logic [20:0] r_cp;
    logic [2:0]  n_len;
    logic [1:0]  n_held;
    logic [20:0] n_cp;

    logic        seq_open;
    logic        is_cont;
    logic        fresh;
    logic [2:0]  held_inc;
    logic [20:0] cp_ext;
    logic [19:0] cp_off;
    logic        bad;
    u8u16_pkg::t_burst burst;

    assign seq_open = (r_len != u8u16_pkg::LEN_NONE);
    assign is_cont  = (i_byte[7:6] == 2'b10);
    assign held_inc = {1'b0, r_held} + 3'd1;
    assign cp_ext   = {r_cp[14:0], i_byte[5:0]};
    assign cp_off   = 20'(cp_ext - u8u16_pkg::PLANE_BASE);

    always_comb begin
        bad = 1'b0;
        if (r_len == u8u16_pkg::LEN_TWO && cp_ext < u8u16_pkg::MIN_LEN2) bad = 1'b1;
        if (r_len == u8u16_pkg::LEN_THREE && cp_ext < u8u16_pkg::MIN_LEN3) bad = 1'b1;
        if (r_len == u8u16_pkg::LEN_FOUR && cp_ext < u8u16_pkg::MIN_LEN4) bad = 1'b1;
        if (cp_ext >= u8u16_pkg::SURR_MIN && cp_ext <= u8u16_pkg::SURR_MAX) bad = 1'b1;
        if (cp_ext > u8u16_pkg::POINT_MAX) bad = 1'b1;
    end

    always_comb begin
        n_len  = r_len;
        n_held = r_held;
        n_cp   = r_cp;
        fresh  = 1'b0;
        burst  = '0;
        if (seq_open) begin
            if (is_cont) begin
                if (held_inc + 3'd1 == r_len) begin
                    n_len  = u8u16_pkg::LEN_NONE;
                    n_held = 2'd0;
                    n_cp   = '0;
                    burst.n_tail = 2'd1;
                    if (bad) begin
                        burst.tail0 = u8u16_pkg::REPL_UNIT;
                    end else if (cp_ext <= u8u16_pkg::BMP_MAX) begin
                        burst.tail0 = cp_ext[15:0];
                    end else begin
                        burst.n_tail = 2'd2;
                        burst.tail0  = u8u16_pkg::HI_SURR | {6'd0, cp_off[19:10]};
                        burst.tail1  = u8u16_pkg::LO_SURR | {6'd0, cp_off[9:0]};
                    end
                end else begin
                    n_held = held_inc[1:0];
                    n_cp   = cp_ext;
                end
            end else begin
                burst.n_repl = {1'b0, r_held} + 3'd1;
                n_len  = u8u16_pkg::LEN_NONE;
                n_held = 2'd0;
                n_cp   = '0;
                fresh  = 1'b1;
            end
        end else begin
            fresh = 1'b1;
        end

        if (fresh) begin
            unique casez (i_byte)
                8'b0???????: begin
                    burst.n_tail = 2'd1;
                    burst.tail0  = {8'd0, i_byte};
                end
                8'b110?????: begin
                    n_len  = u8u16_pkg::LEN_TWO;
                    n_held = 2'd0;
                    n_cp   = {16'd0, i_byte[4:0]};
                end
                8'b1110????: begin
                    n_len  = u8u16_pkg::LEN_THREE;
                    n_held = 2'd0;
                    n_cp   = {17'd0, i_byte[3:0]};
                end
                8'b11110???: begin
                    n_len  = u8u16_pkg::LEN_FOUR;
                    n_held = 2'd0;
                    n_cp   = {18'd0, i_byte[2:0]};
                end
                default: begin
                    burst.n_repl = burst.n_repl + 3'd1;
                end
            endcase
        end

        if (i_end) begin
            if (n_len != u8u16_pkg::LEN_NONE) begin
                burst.n_repl = burst.n_repl + {1'b0, n_held} + 3'd1;
            end
            n_len  = u8u16_pkg::LEN_NONE;
            n_held = 2'd0;
            n_cp   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= u8u16_pkg::LEN_NONE;
            r_held <= 2'd0;
            r_cp   <= '0;
        end else if (i_accept) begin
            r_len  <= n_len;
            r_held <= n_held;
            r_cp   <= n_cp;
        end
    end

    assign o_push  = i_accept && ((burst.n_repl != 3'd0) || (burst.n_tail != 2'd0));
    assign o_burst = burst;

endmodule

// ===== sv/u8u16_queue.sv =====
module u8u16_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  u8u16_pkg::t_burst   i_burst,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output u8u16_pkg::t_burst   o_head
);

    localparam int CNT_W = u8u16_pkg::QPTR_W + 1;

    u8u16_pkg::t_burst r_mem [u8u16_pkg::QUEUE_DEPTH];
    logic [u8u16_pkg::QPTR_W-1:0] r_wr;
    logic [u8u16_pkg::QPTR_W-1:0] r_rd;
    logic [CNT_W-1:0]             r_cnt;

    assign o_full  = (r_cnt == CNT_W'(u8u16_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_burst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + u8u16_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + u8u16_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// ===== sv/u8u16_serialize.sv =====
module u8u16_serialize (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  u8u16_pkg::t_burst   i_head,
    input  logic                i_ready,
    output logic                o_pop,
    output logic                o_valid,
    output logic [15:0]         o_unit,
    output logic                o_last
);

    logic [1:0] r_idx;
    logic [2:0] total;
    logic [2:0] tail_pos;

    assign total    = i_head.n_repl + {1'b0, i_head.n_tail};
    assign tail_pos = {1'b0, r_idx} - i_head.n_repl;
    assign o_valid  = i_valid;
    assign o_last   = ({1'b0, r_idx} == total - 3'd1);
    assign o_pop    = i_valid && i_ready && o_last;

    always_comb begin
        if ({1'b0, r_idx} < i_head.n_repl) begin
            o_unit = u8u16_pkg::REPL_UNIT;
        end else if (tail_pos[0]) begin
            o_unit = i_head.tail1;
        end else begin
            o_unit = i_head.tail0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (i_valid && i_ready) begin
            if (o_last) begin
                r_idx <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

// ===== sv/utf8_to_utf16_transcoder_top.sv =====
// channel   dir   tdata                tlast
// s_axis    in    [7:0] byte_in        string_end
// m_axis    out   [15:0] code_unit     run_last
//
// One byte is taken per cycle while the four-entry burst queue has room.
// Each queued byte gives up to four words, shown one per cycle from the queue head.
// A byte that gives at most one word sustains one byte per cycle.
// Synchronous active-low reset closes any open sequence and empties the queue.
// Output stalls hold the head word; input stalls only when the queue is full.
module utf8_to_utf16_transcoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tvalid,
    output logic        o_tready,
    input  logic [7:0]  i_tdata,    // [7:0] byte_in
    input  logic        i_tlast,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [15:0] o_tdata,    // [15:0] code_unit
    output logic        o_tlast
);

    logic              accept;
    logic              push;
    logic              pop;
    logic              full;
    logic              head_valid;
    u8u16_pkg::t_burst burst;
    u8u16_pkg::t_burst head;

    assign o_tready = !full;
    assign accept   = i_tvalid && !full;

    u8u16_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_tdata),
        .i_end    (i_tlast),
        .o_push   (push),
        .o_burst  (burst)
    );

    u8u16_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_burst  (burst),
        .i_pop    (pop),
        .o_full   (full),
        .o_valid  (head_valid),
        .o_head   (head)
    );

    u8u16_serialize u_serialize (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (head_valid),
        .i_head   (head),
        .i_ready  (i_tready),
        .o_pop    (pop),
        .o_valid  (o_tvalid),
        .o_unit   (o_tdata),
        .o_last   (o_tlast)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        logic [15:0] unit;
        logic        last;
    } t_word;

    class utf16_scoreboard;
        t_word      want_q[$];
        int         errors;
        logic [2:0]  seq_len;
        logic [1:0]  cont_cnt;
        logic [20:0] acc;

        function new();
            errors   = 0;
            seq_len  = u8u16_pkg::LEN_NONE;
            cont_cnt = 2'd0;
            acc      = 21'd0;
        endfunction

        function void put_unit(logic [15:0] u);
            t_word w;
            w.unit = u;
            w.last = 1'b0;
            want_q.push_back(w);
        endfunction

        function void close_seq();
            seq_len  = u8u16_pkg::LEN_NONE;
            cont_cnt = 2'd0;
            acc      = 21'd0;
        endfunction

        function void flush_open(int cnt);
            for (int k = 0; k < cnt; k++) put_unit(u8u16_pkg::REPL_UNIT);
            close_seq();
        endfunction

        function void decode_fresh(logic [7:0] b);
            if (b < 8'h80) begin
                put_unit({8'h00, b});
            end else if (b[7:5] == 3'b110) begin
                seq_len = u8u16_pkg::LEN_TWO;   cont_cnt = 2'd0; acc = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                seq_len = u8u16_pkg::LEN_THREE; cont_cnt = 2'd0; acc = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
                seq_len = u8u16_pkg::LEN_FOUR;  cont_cnt = 2'd0; acc = {18'd0, b[2:0]};
            end else begin
                put_unit(u8u16_pkg::REPL_UNIT);
            end
        endfunction

        function void note_byte(logic [7:0] b, logic str_end);
            int          start;
            int          held;
            logic [2:0]  len;
            logic [20:0] cp;
            logic [20:0] v;
            logic        bad;
            t_word       w;
            start = want_q.size();
            if (seq_len != u8u16_pkg::LEN_NONE) begin
                if (b[7:6] == 2'b10) begin
                    held = cont_cnt + 1;
                    acc  = {acc[14:0], b[5:0]};
                    if (held + 1 >= seq_len) begin
                        len = seq_len;
                        cp  = acc;
                        close_seq();
                        bad = 1'b0;
                        if (len == u8u16_pkg::LEN_TWO && cp < u8u16_pkg::MIN_LEN2) bad = 1'b1;
                        if (len == u8u16_pkg::LEN_THREE && cp < u8u16_pkg::MIN_LEN3) bad = 1'b1;
                        if (len == u8u16_pkg::LEN_FOUR && cp < u8u16_pkg::MIN_LEN4) bad = 1'b1;
                        if (cp >= u8u16_pkg::SURR_MIN && cp <= u8u16_pkg::SURR_MAX) bad = 1'b1;
                        if (cp > u8u16_pkg::POINT_MAX) bad = 1'b1;
                        if (bad) begin
                            put_unit(u8u16_pkg::REPL_UNIT);
                        end else if (cp <= u8u16_pkg::BMP_MAX) begin
                            put_unit(cp[15:0]);
                        end else begin
                            v = cp - u8u16_pkg::PLANE_BASE;
                            put_unit(u8u16_pkg::HI_SURR | {6'd0, v[19:10]});
                            put_unit(u8u16_pkg::LO_SURR | {6'd0, v[9:0]});
                        end
                    end else begin
                        cont_cnt = held[1:0];
                    end
                end else begin
                    flush_open(1 + cont_cnt);
                    decode_fresh(b);
                end
            end else begin
                close_seq();
                decode_fresh(b);
            end
            if (str_end) begin
                if (seq_len != u8u16_pkg::LEN_NONE) flush_open(1 + cont_cnt);
                else close_seq();
            end
            if (want_q.size() > start) begin
                w = want_q.pop_back();
                w.last = 1'b1;
                want_q.push_back(w);
            end
        endfunction

        function void check_word(logic [15:0] unit, logic last);
            t_word w;
            if (want_q.size() == 0) begin
                $error("unexpected word: code_unit %h run_last %b", unit, last);
                errors++;
            end else begin
                w = want_q.pop_front();
                if (unit !== w.unit) begin
                    $error("code_unit: expected %h, actual %h", w.unit, unit);
                    errors++;
                end
                if (last !== w.last) begin
                    $error("run_last: expected %b, actual %b", w.last, last);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_tvalid;
    logic        o_tready;
    logic [7:0]  i_tdata;
    logic        i_tlast;
    logic        o_tvalid;
    logic        i_tready;
    logic [15:0] o_tdata;
    logic        o_tlast;

    int send_idle;
    int recv_idle;
    int sent_cnt;

    utf16_scoreboard sb;

    utf8_to_utf16_transcoder_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_tvalid),
        .o_tready (o_tready),
        .i_tdata  (i_tdata),
        .i_tlast  (i_tlast),
        .o_tvalid (o_tvalid),
        .i_tready (i_tready),
        .o_tdata  (o_tdata),
        .o_tlast  (o_tlast)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_tready = ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_tvalid && o_tready) sb.note_byte(i_tdata, i_tlast);
            if (o_tvalid && i_tready) sb.check_word(o_tdata, o_tlast);
        end
    end

    task automatic push_byte(logic [7:0] b, logic last);
        while ($urandom_range(0, 99) < send_idle) begin
            i_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_tvalid = 1'b1;
        i_tdata  = b;
        i_tlast  = last;
        @(posedge i_clk);
        while (!o_tready) @(posedge i_clk);
        sent_cnt++;
        @(negedge i_clk);
    endtask

    task automatic send_sequence();
        logic [7:0]  seq[$];
        logic [7:0]  nb;
        logic [20:0] cp;
        int          kind;
        int          len;
        int          idx;
        int          drop;
        logic        flag_end;
        kind = $urandom_range(0, 9);
        len  = $urandom_range(1, 4);
        if (kind == 9) begin
            seq.push_back(8'($urandom_range(0, 255)));
        end else begin
            case (len)
                1: cp = 21'($urandom_range(0, 'h7F));
                2: cp = 21'($urandom_range('h80, 'h7FF));
                3: cp = 21'($urandom_range('h800, 'hFFFF));
                default: cp = 21'($urandom_range('h10000, 'h10FFFF));
            endcase
            if (kind == 6) begin
                case (len)
                    2: cp = 21'($urandom_range(0, 'h7F));
                    3: cp = 21'($urandom_range(0, 'h7FF));
                    4: begin
                        if ($urandom_range(0, 1)) cp = 21'($urandom_range(0, 'hFFFF));
                        else cp = 21'($urandom_range('h110000, 'h1FFFFF));
                    end
                    default: ;
                endcase
            end
            case (len)
                1: seq.push_back({1'b0, cp[6:0]});
                2: begin
                    seq.push_back({3'b110, cp[10:6]});
                    seq.push_back({2'b10, cp[5:0]});
                end
                3: begin
                    seq.push_back({4'b1110, cp[15:12]});
                    seq.push_back({2'b10, cp[11:6]});
                    seq.push_back({2'b10, cp[5:0]});
                end
                default: begin
                    seq.push_back({5'b11110, cp[20:18]});
                    seq.push_back({2'b10, cp[17:12]});
                    seq.push_back({2'b10, cp[11:6]});
                    seq.push_back({2'b10, cp[5:0]});
                end
            endcase
            if (kind == 7 && seq.size() > 1) begin
                drop = $urandom_range(1, seq.size() - 1);
                repeat (drop) void'(seq.pop_back());
            end
            if (kind == 8 && seq.size() > 1) begin
                idx = $urandom_range(1, seq.size() - 1);
                nb  = 8'($urandom_range(0, 255));
                while (nb[7:6] == 2'b10) nb = 8'($urandom_range(0, 255));
                seq[idx] = nb;
            end
        end
        flag_end = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < seq.size(); k++) begin
            push_byte(seq[k], (k == seq.size() - 1) ? flag_end
                                                    : ($urandom_range(0, 29) == 0));
        end
    endtask

    logic [8:0] directed [24] = '{
        9'h000, 9'h17F,
        9'h0C3, 9'h0A9,
        9'h0C0, 9'h080,
        9'h0F0, 9'h09F, 9'h098, 9'h080,
        9'h0F4, 9'h090, 9'h080, 9'h080,
        9'h0ED, 9'h0A0, 9'h080,
        9'h0FF,
        9'h0E2, 9'h082, 9'h041,
        9'h0F4, 9'h18F,
        9'h180
    };

    initial begin
        sb        = new();
        i_rst_n   = 1'b0;
        i_tvalid  = 1'b0;
        i_tdata   = 8'h00;
        i_tlast   = 1'b0;
        i_tready  = 1'b0;
        send_idle = 13;
        recv_idle = 59;
        sent_cnt  = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < 24; k++) push_byte(directed[k][7:0], directed[k][8]);

        while (sent_cnt < 76) send_sequence();
        send_idle = 59;
        recv_idle = 13;
        while (sent_cnt < 128) send_sequence();
        send_idle = 0;
        recv_idle = 0;
        while (sent_cnt < 180) send_sequence();
        i_tvalid = 1'b0;
        i_tlast  = 1'b0;

        while (sb.pending() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (sb.pending() != 0) begin
            $error("words still expected at end: %0d", sb.pending());
            sb.errors++;
        end

        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_400_000;
        $display("status: fail");
        $finish;
    end

endmodule
